>>> design/compacting_list_store_top_assert.svh
// Assertion macros shared by the list store checker.
`ifndef COMPACTING_LIST_STORE_TOP_ASSERT_SVH
`define COMPACTING_LIST_STORE_TOP_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define CLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cls_pkg.sv
// Shared constants, codes and types of the compacting list store.
`timescale 1ns / 1ps

package cls_pkg;

	localparam int DEF_CAPACITY = 128;

	// Field widths of the request and result items.
	localparam int OP_W    = 3;
	localparam int VAL_W   = 32;
	localparam int FI_W    = 7;
	localparam int LI_W    = 8;
	localparam int POS_W   = 7;
	localparam int CNTO_W  = 8;
	localparam int STAT_W  = 2;
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 8;
	localparam int M_TDATA_W = 56;

	// Width of index and count compares; covers every capacity up to 1024.
	localparam int CMP_W = 11;

	// Cells per reduction segment.
	localparam int SEG_N  = 8;
	localparam int SEG_IW = 3;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
	localparam logic [OP_W-1:0] OP_RANGE  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              cmp_find;
		logic              cmp_read;
		logic              append;
		logic              shift;
		logic [CMP_W-1:0]  fi;
		logic [CMP_W-1:0]  count;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	// Registered summary of one segment of cells.
	typedef struct packed {
		logic              any;
		logic [SEG_IW-1:0] idx;
		logic [VAL_W-1:0]  data;
	} seg_res_t;

endpackage

>>> design/cls_cell.sv
// One storage cell of the list: holds an entry, shifts down and compares.
`timescale 1ns / 1ps

module cls_cell #(
	parameter int INDEX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cls_pkg::cmd_t               cmd,
	input  logic [cls_pkg::VAL_W-1:0]   up_entry,
	output logic [cls_pkg::VAL_W-1:0]   entry,
	output logic                        hit,
	output logic [cls_pkg::VAL_W-1:0]   rd_data
);

	localparam int CW = cls_pkg::CMP_W;
	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic [cls_pkg::VAL_W-1:0] entry_q;
	logic [cls_pkg::VAL_W-1:0] rd_data_q;
	logic                      hit_q;
	logic                      live;
	logic                      is_fi;

	assign live  = IDX < cmd.count;
	assign is_fi = IDX == cmd.fi;

	// During an erase every cell at or above the gap takes its upper neighbor.
	always_ff @(posedge clk) begin
		if (cmd.shift && (IDX >= cmd.fi)) begin
			entry_q <= up_entry;
		end else if (cmd.append && (IDX == cmd.count)) begin
			entry_q <= cmd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= live && ((cmd.cmp_find && (entry_q == cmd.value)) ||
				(cmd.cmp_read && is_fi));
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= (live && cmd.cmp_read && is_fi) ? entry_q : '0;
	end

	assign entry   = entry_q;
	assign hit     = hit_q;
	assign rd_data = rd_data_q;

endmodule

>>> design/cls_seg.sv
// Reduces one segment of cells to its lowest hit and the read data.
`timescale 1ns / 1ps

module cls_seg (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [cls_pkg::SEG_N-1:0]                     hits,
	input  logic [cls_pkg::SEG_N-1:0][cls_pkg::VAL_W-1:0] data,
	output cls_pkg::seg_res_t                             res
);

	cls_pkg::seg_res_t res_c;
	cls_pkg::seg_res_t res_q;

	always_comb begin
		res_c.any  = |hits;
		res_c.idx  = '0;
		res_c.data = '0;
		for (int i = cls_pkg::SEG_N - 1; i >= 0; i--) begin
			if (hits[i]) begin
				res_c.idx = cls_pkg::SEG_IW'(i);
			end
			res_c.data = res_c.data | data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_c;
		end
	end

	assign res = res_q;

endmodule

>>> design/compacting_list_store_top.sv
// Top level of the compacting list store: command FSM, cell chain and result reduction.
`timescale 1ns / 1ps

// The block keeps an ordered, packed list of signed 32-bit values in a row of
// CAPACITY cells, plus a count of the entries in use.
// Requests arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser),
// with the operation code in s_tuser. Each request produces exactly one result
// on the master stream (m_tvalid, m_tready, m_tdata) carrying read data, find
// position and flag, the count after the operation, and a status code.
// The block handles one request at a time and takes a new one only while the
// control sequencer is idle. Append, read, find, clear, unused codes and refused
// erases pass in order through command decode with cell compare, segment
// reduction and final select before the result enters the output register.
// Erasing moves every later entry down one cell per cycle, once per entry
// removed, in place of the reduction step, and then goes on to final select.
// The next request is accepted in the cycle after the previous result is loaded.
// A finished result waits in the output register while the receiver stalls,
// and the next request is already taken; its own result is held back until
// the waiting one has been taken. Reset empties the list and drops any pending
// result; stored values are not cleared since an entry is never read unwritten.
module compacting_list_store_top #(
	parameter int CAPACITY = cls_pkg::DEF_CAPACITY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// value [31:0], first_index [38:32], last_index [46:39], zero fill above
	input  logic [cls_pkg::S_TDATA_W-1:0]    s_tdata,
	// op [2:0], zero fill above
	input  logic [cls_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// data [31:0], position [38:32], found [39], count [47:40], status [49:48],
	// zero fill above
	output logic [cls_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam int CW    = cls_pkg::CMP_W;
	localparam int VW    = cls_pkg::VAL_W;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int NSEG  = (CAPACITY + cls_pkg::SEG_N - 1) / cls_pkg::SEG_N;
	localparam int NPAD  = NSEG * cls_pkg::SEG_N;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_SEG   = 6'b000100,
		S_FIN   = 6'b001000,
		S_SHIFT = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q;

	// Latched request.
	logic [cls_pkg::OP_W-1:0]  op_q;
	logic [VW-1:0]             value_q;
	logic [cls_pkg::FI_W-1:0]  fi_q;
	logic [cls_pkg::LI_W-1:0]  li_q;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          shift_cnt_q;
	logic [cls_pkg::STAT_W-1:0] status_q;

	// Result held until the output register is free.
	logic [VW-1:0]             res_data_q;
	logic [cls_pkg::POS_W-1:0] res_pos_q;
	logic                      res_found_q;

	// Output register.
	logic                      m_tvalid_q;
	logic [cls_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                      out_load_c;

	logic [CW-1:0] fi_ext;
	logic [CW-1:0] li_ext;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] gap_c;
	logic [CW-1:0] cnt_less_gap;
	logic          full_c;
	logic          fi_bad_c;
	logic          rng_bad_c;

	cls_pkg::cmd_t cmd;

	logic [NPAD-1:0]         hit_all;
	logic [NPAD-1:0][VW-1:0] rdat_all;
	logic [CAPACITY-1:0][VW-1:0] cell_entry;
	cls_pkg::seg_res_t       seg_res [NSEG];

	logic          any_c;
	logic [CW-1:0] pos_c;
	logic [VW-1:0] data_c;

	assign fi_ext       = CW'(fi_q);
	assign li_ext       = CW'(li_q);
	assign cnt_ext      = CW'(count_q);
	assign full_c       = cnt_ext >= CW'(CAPACITY);
	assign fi_bad_c     = fi_ext >= cnt_ext;
	assign rng_bad_c    = !((fi_ext < li_ext) && (li_ext <= cnt_ext));
	assign gap_c        = (op_q == cls_pkg::OP_ERASE) ? CW'(1) : (li_ext - fi_ext);
	assign cnt_less_gap = cnt_ext - gap_c;

	// The finished result moves to the output register once that is free.
	assign out_load_c = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	// Command broadcast along the cell chain.
	always_comb begin
		cmd.cmp_find = (state_q == S_EXEC) && (op_q == cls_pkg::OP_FIND);
		cmd.cmp_read = (state_q == S_EXEC) && (op_q == cls_pkg::OP_READ);
		cmd.append   = (state_q == S_EXEC) && (op_q == cls_pkg::OP_APPEND) && !full_c;
		cmd.shift    = state_q == S_SHIFT;
		cmd.fi       = fi_ext;
		cmd.count    = cnt_ext;
		cmd.value    = value_q;
	end

	for (genvar k = 0; k < NPAD; k++) begin : g_cell
		if (k < CAPACITY) begin : g_live
			logic [VW-1:0] up;
			if (k == CAPACITY - 1) begin : g_top
				assign up = cell_entry[k];
			end else begin : g_mid
				assign up = cell_entry[k + 1];
			end
			cls_cell #(
				.INDEX (k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.up_entry (up),
				.entry    (cell_entry[k]),
				.hit      (hit_all[k]),
				.rd_data  (rdat_all[k])
			);
		end else begin : g_pad
			assign hit_all[k]  = 1'b0;
			assign rdat_all[k] = '0;
		end
	end

	for (genvar g = 0; g < NSEG; g++) begin : g_seg
		cls_seg u_seg (
			.clk    (clk),
			.arst_n (arst_n),
			.hits   (hit_all[g*cls_pkg::SEG_N +: cls_pkg::SEG_N]),
			.data   (rdat_all[g*cls_pkg::SEG_N +: cls_pkg::SEG_N]),
			.res    (seg_res[g])
		);
	end

	// Lowest segment with a hit gives the position; read data is one-hot.
	always_comb begin
		any_c  = 1'b0;
		pos_c  = '0;
		data_c = '0;
		for (int g = NSEG - 1; g >= 0; g--) begin
			if (seg_res[g].any) begin
				any_c = 1'b1;
				pos_c = (CW'(g) << cls_pkg::SEG_IW) | CW'(seg_res[g].idx);
			end
			data_c = data_c | seg_res[g].data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load_c) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			shift_cnt_q <= '0;
			status_q    <= cls_pkg::STAT_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= cls_pkg::STAT_OK;
					state_q  <= S_SEG;
					case (op_q)
						cls_pkg::OP_APPEND: begin
							if (full_c) begin
								status_q <= cls_pkg::STAT_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						cls_pkg::OP_READ: begin
							if (fi_bad_c) begin
								status_q <= cls_pkg::STAT_BAD;
							end
						end
						cls_pkg::OP_ERASE: begin
							if (fi_bad_c) begin
								status_q <= cls_pkg::STAT_BAD;
							end else begin
								count_q     <= cnt_less_gap[CNT_W-1:0];
								shift_cnt_q <= gap_c[CNT_W-1:0];
								state_q     <= S_SHIFT;
							end
						end
						cls_pkg::OP_RANGE: begin
							if (rng_bad_c) begin
								status_q <= cls_pkg::STAT_BAD;
							end else begin
								count_q     <= cnt_less_gap[CNT_W-1:0];
								shift_cnt_q <= gap_c[CNT_W-1:0];
								state_q     <= S_SHIFT;
							end
						end
						cls_pkg::OP_CLEAR: begin
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_SHIFT: begin
					shift_cnt_q <= shift_cnt_q - CNT_W'(1);
					if (shift_cnt_q == CNT_W'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_SEG: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_load_c) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tuser[cls_pkg::OP_W-1:0];
			value_q <= s_tdata[VW-1:0];
			fi_q    <= s_tdata[VW +: cls_pkg::FI_W];
			li_q    <= s_tdata[VW + cls_pkg::FI_W +: cls_pkg::LI_W];
		end
		if (state_q == S_FIN) begin
			res_data_q  <= (op_q == cls_pkg::OP_READ) ? data_c : '0;
			res_found_q <= any_c && (op_q == cls_pkg::OP_FIND);
			res_pos_q   <= (any_c && (op_q == cls_pkg::OP_FIND)) ?
				pos_c[cls_pkg::POS_W-1:0] : '0;
		end
		if (out_load_c) begin
			m_tdata_q <= {6'b0, status_q, cnt_ext[cls_pkg::CNTO_W-1:0], res_found_q,
				res_pos_q, res_data_q};
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> design/cls_checker.sv
// Port-level checker of the compacting list store and its bind.
`timescale 1ns / 1ps
`include "compacting_list_store_top_assert.svh"

module cls_checker #(
	parameter int CAPACITY = cls_pkg::DEF_CAPACITY
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cls_pkg::M_TDATA_W-1:0] m_tdata
);

	logic [cls_pkg::STAT_W-1:0] m_status;
	logic [cls_pkg::CNTO_W-1:0] m_count;
	logic                       m_found;

	assign m_status = m_tdata[49:48];
	assign m_count  = m_tdata[47:40];
	assign m_found  = m_tdata[39];

	// A stalled result must stay put until it is taken.
	`CLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Only one request is in flight, so the input closes right after a request.
	`CLS_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// A successful find always reports ok status.
	`CLS_ASSERT_NOW(a_found_ok, m_tvalid && m_found, m_status == cls_pkg::STAT_OK, "found with bad status")

	// A refused append means the list holds exactly its capacity.
	`CLS_ASSERT_NOW(a_full_count, m_tvalid && (m_status == cls_pkg::STAT_FULL), m_count == 8'(CAPACITY), "full status with wrong count")

	// The count never exceeds the capacity.
	`CLS_ASSERT_NOW(a_count_max, m_tvalid, (CAPACITY > 255) || (m_count <= CAPACITY), "count above capacity")

endmodule

bind compacting_list_store_top cls_checker #(
	.CAPACITY (CAPACITY)
) u_cls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> test/compacting_list_store_top_tb.sv
// Self-checking testbench of the compacting list store with a reply scoreboard.
`timescale 1ns / 1ps

module compacting_list_store_top_tb;

	localparam int CAP             = cls_pkg::DEF_CAPACITY;
	localparam int MAX_CYCLES      = 1_000_000;
	localparam int RANDOM_REQUESTS = 900;
	localparam int REPORT_LIMIT    = 10;

	// Op codes that the block must treat as no-ops.
	localparam logic [cls_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [cls_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [cls_pkg::VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [cls_pkg::VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
	localparam logic [cls_pkg::VAL_W-1:0] VAL_ZERO = 32'h0000_0000;
	localparam logic [cls_pkg::VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_LONG_STALLS} ready_mode_t;

	typedef struct {
		logic signed [cls_pkg::VAL_W-1:0] data;
		logic [cls_pkg::POS_W-1:0]        position;
		logic                             found;
		logic [cls_pkg::CNTO_W-1:0]       count;
		logic [cls_pkg::STAT_W-1:0]       status;
	} list_reply_t;

	class list_scoreboard;
		logic signed [cls_pkg::VAL_W-1:0] shadow_entries [CAP];
		int                               shadow_count;
		list_reply_t                      awaited_replies [$];
		int                               failures;

		function new();
			shadow_count = 0;
			failures = 0;
		endfunction

		// Removes [lo, hi) and moves the later entries down.
		function void close_gap(int lo, int hi);
			int k;
			for (k = hi; k < shadow_count; k++)
				shadow_entries[k - (hi - lo)] = shadow_entries[k];
			shadow_count -= hi - lo;
		endfunction

		function void flag(string what);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%s", what);
		endfunction

		function void note_request(logic [cls_pkg::OP_W-1:0] op,
				logic signed [cls_pkg::VAL_W-1:0] value,
				logic [cls_pkg::FI_W-1:0] fi, logic [cls_pkg::LI_W-1:0] li);
			list_reply_t r;
			int k;
			r.data = '0;
			r.position = '0;
			r.found = 1'b0;
			r.status = cls_pkg::STAT_OK;
			case (op)
				cls_pkg::OP_APPEND: begin
					if (shadow_count >= CAP) begin
						r.status = cls_pkg::STAT_FULL;
					end else begin
						shadow_entries[shadow_count] = value;
						shadow_count++;
					end
				end
				cls_pkg::OP_READ: begin
					if (int'(fi) < shadow_count)
						r.data = shadow_entries[fi];
					else
						r.status = cls_pkg::STAT_BAD;
				end
				cls_pkg::OP_ERASE: begin
					if (int'(fi) < shadow_count)
						close_gap(int'(fi), int'(fi) + 1);
					else
						r.status = cls_pkg::STAT_BAD;
				end
				cls_pkg::OP_RANGE: begin
					if (fi < li && int'(li) <= shadow_count)
						close_gap(int'(fi), int'(li));
					else
						r.status = cls_pkg::STAT_BAD;
				end
				cls_pkg::OP_CLEAR: shadow_count = 0;
				cls_pkg::OP_FIND: begin
					for (k = 0; k < shadow_count && !r.found; k++) begin
						if (shadow_entries[k] == value) begin
							r.found = 1'b1;
							r.position = cls_pkg::POS_W'(k);
						end
					end
				end
				default: ;
			endcase
			r.count = cls_pkg::CNTO_W'(shadow_count);
			awaited_replies.insert(awaited_replies.size(), r);
		endfunction

		function void check_result(logic [cls_pkg::M_TDATA_W-1:0] word);
			list_reply_t want;
			list_reply_t got;
			got.data = word[31:0];
			got.position = word[38:32];
			got.found = word[39];
			got.count = word[47:40];
			got.status = word[49:48];
			if (awaited_replies.size() == 0) begin
				flag($sformatf({"unexpected reply: data %h pos %0d found %0b count %0d ",
					"status %0d"},
					got.data, got.position, got.found, got.count, got.status));
				return;
			end
			want = awaited_replies.pop_front();
			if (got.data !== want.data || got.position !== want.position ||
					got.found !== want.found || got.count !== want.count ||
					got.status !== want.status)
				flag($sformatf({"reply mismatch: expected data %h pos %0d found %0b count %0d ",
					"status %0d, got data %h pos %0d found %0b count %0d status %0d"},
					want.data, want.position, want.found, want.count, want.status,
					got.data, got.position, got.found, got.count, got.status));
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [cls_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [cls_pkg::S_TUSER_W-1:0] s_tuser = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [cls_pkg::M_TDATA_W-1:0] m_tdata;

	list_scoreboard sb;
	int             burst_left = 0;
	int             requests_sent = 0;
	int             cycle_count = 0;
	ready_mode_t    ready_mode = READY_ALWAYS;
	int             mode_left = 0;
	int             stall_left = 0;

	compacting_list_store_top #(.CAPACITY(CAP)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("compacting_list_store_top verification failed");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	// The receiver switches between always ready, coin flips and long stalls.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 2));
			mode_left <= $urandom_range(40, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN: m_tready <= 1'($urandom_range(0, 1));
			default: begin
				if (stall_left != 0) begin
					m_tready <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					m_tready <= 1'b1;
					stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(4, 24) : 0;
				end
			end
		endcase
	end

	// Drives one request within the current burst; a new burst may start after a gap.
	task automatic send_request(logic [cls_pkg::OP_W-1:0] op,
			logic [cls_pkg::VAL_W-1:0] value,
			logic [cls_pkg::FI_W-1:0] fi, logic [cls_pkg::LI_W-1:0] li);
		logic [cls_pkg::S_TDATA_W-1:0] word;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 20);
		end
		burst_left--;
		word = '0;
		word[31:0] = value;
		word[38:32] = fi;
		word[46:39] = li;
		s_tdata <= word;
		s_tuser <= cls_pkg::S_TUSER_W'(op);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, value, fi, li);
		requests_sent++;
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// Extremes, a small pool that makes duplicates for find, and free random values.
	function automatic logic [cls_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_ZERO;
				default: return VAL_NEG1;
			endcase
		end
		if (r < 40)
			return cls_pkg::VAL_W'($urandom_range(0, 7)) * 32'h2468_ace1;
		return $urandom;
	endfunction

	function automatic logic [cls_pkg::FI_W-1:0] pick_index();
		if (sb.shadow_count > 0 && $urandom_range(0, 9) != 0)
			return cls_pkg::FI_W'($urandom_range(0, sb.shadow_count - 1));
		return cls_pkg::FI_W'($urandom_range(0, CAP - 1));
	endfunction

	task automatic send_append();
		send_request(cls_pkg::OP_APPEND, pick_value(), cls_pkg::FI_W'($urandom),
			cls_pkg::LI_W'($urandom));
	endtask

	task automatic send_noise();
		send_request(cls_pkg::OP_W'($urandom_range(0, 7)), $urandom,
			cls_pkg::FI_W'($urandom), cls_pkg::LI_W'($urandom));
	endtask

	task automatic send_find();
		logic [cls_pkg::VAL_W-1:0] v;
		if (sb.shadow_count > 0 && $urandom_range(0, 2) != 0)
			v = sb.shadow_entries[$urandom_range(0, sb.shadow_count - 1)];
		else
			v = pick_value();
		send_request(cls_pkg::OP_FIND, v, cls_pkg::FI_W'($urandom),
			cls_pkg::LI_W'($urandom));
	endtask

	// Mostly short valid ranges; now and then the whole tail, or arbitrary bounds.
	task automatic send_range_erase();
		int lo;
		int len;
		if (sb.shadow_count == 0 || $urandom_range(0, 7) == 0) begin
			send_request(cls_pkg::OP_RANGE, $urandom,
				cls_pkg::FI_W'($urandom_range(0, CAP - 1)),
				cls_pkg::LI_W'($urandom_range(0, 255)));
		end else begin
			lo = $urandom_range(0, sb.shadow_count - 1);
			len = ($urandom_range(0, 19) == 0) ? sb.shadow_count - lo : $urandom_range(1, 6);
			if (lo + len > sb.shadow_count)
				len = sb.shadow_count - lo;
			send_request(cls_pkg::OP_RANGE, $urandom, cls_pkg::FI_W'(lo),
				cls_pkg::LI_W'(lo + len));
		end
	endtask

	task automatic send_mixed_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			send_append();
		else if (r < 48)
			send_request(cls_pkg::OP_READ, $urandom, pick_index(), cls_pkg::LI_W'($urandom));
		else if (r < 58)
			send_request(cls_pkg::OP_ERASE, $urandom, pick_index(), cls_pkg::LI_W'($urandom));
		else if (r < 68)
			send_range_erase();
		else if (r < 88)
			send_find();
		else if (r < 91)
			send_request(cls_pkg::OP_CLEAR, $urandom, cls_pkg::FI_W'($urandom),
				cls_pkg::LI_W'($urandom));
		else
			send_noise();
	endtask

	// Fills the list, tries appends that must be refused, then works at the top end.
	task automatic fill_to_capacity();
		int tail;
		while (sb.shadow_count < CAP)
			send_append();
		repeat ($urandom_range(2, 4)) send_append();
		send_request(cls_pkg::OP_READ, $urandom, cls_pkg::FI_W'(CAP - 1),
			cls_pkg::LI_W'($urandom));
		send_request(cls_pkg::OP_FIND, sb.shadow_entries[CAP - 1], cls_pkg::FI_W'($urandom),
			cls_pkg::LI_W'($urandom));
		tail = $urandom_range(1, 4);
		send_request(cls_pkg::OP_RANGE, $urandom, cls_pkg::FI_W'(CAP - tail),
			cls_pkg::LI_W'(CAP));
	endtask

	initial begin
		int stop_at;
		int midway;
		int kind;
		bit paused_midway;
		sb = new();
		paused_midway = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: empty list, extremes, duplicates, every op and bad cases.
		send_request(cls_pkg::OP_READ, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_ERASE, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_RANGE, VAL_ZERO, 7'd0, 8'd1);
		send_request(cls_pkg::OP_FIND, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_APPEND, VAL_MIN, 7'd0, 8'd0);
		send_request(cls_pkg::OP_APPEND, VAL_MAX, 7'd127, 8'd255);
		send_request(cls_pkg::OP_APPEND, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_APPEND, VAL_NEG1, 7'd0, 8'd0);
		send_request(cls_pkg::OP_APPEND, VAL_MAX, 7'd0, 8'd0);
		send_request(cls_pkg::OP_READ, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_READ, VAL_ZERO, 7'd3, 8'd0);
		send_request(cls_pkg::OP_READ, VAL_ZERO, 7'd5, 8'd0);
		send_request(cls_pkg::OP_FIND, VAL_MAX, 7'd0, 8'd0);
		send_request(cls_pkg::OP_FIND, 32'h1234_5678, 7'd0, 8'd0);
		send_request(cls_pkg::OP_ERASE, VAL_ZERO, 7'd1, 8'd0);
		send_request(cls_pkg::OP_RANGE, VAL_ZERO, 7'd2, 8'd2);
		send_request(cls_pkg::OP_RANGE, VAL_ZERO, 7'd1, 8'd9);
		send_request(cls_pkg::OP_RANGE, VAL_ZERO, 7'd3, 8'd1);
		send_request(cls_pkg::OP_RANGE, VAL_ZERO, 7'd0, 8'd2);
		send_request(OP_SPARE_6, VAL_NEG1, 7'd127, 8'd255);
		send_request(OP_SPARE_7, VAL_NEG1, 7'd127, 8'd255);
		send_request(cls_pkg::OP_RANGE, VAL_ZERO, 7'd127, 8'd255);
		send_request(cls_pkg::OP_CLEAR, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_READ, VAL_ZERO, 7'd0, 8'd0);
		send_request(cls_pkg::OP_APPEND, 32'h5555_aaaa, 7'd0, 8'd0);

		// Hold the sender off until every directed reply is back.
		wait_for_replies();

		stop_at = requests_sent + RANDOM_REQUESTS;
		midway = requests_sent + RANDOM_REQUESTS / 2;
		fill_to_capacity();
		while (requests_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 3) begin
				fill_to_capacity();
			end else if (kind < 50) begin
				repeat ($urandom_range(6, 24)) send_mixed_request();
			end else if (kind < 65) begin
				repeat ($urandom_range(2, 8)) send_append();
				repeat ($urandom_range(2, 8)) begin
					if ($urandom_range(0, 1) != 0)
						send_range_erase();
					else
						send_request(cls_pkg::OP_ERASE, $urandom, pick_index(),
							cls_pkg::LI_W'($urandom));
				end
			end else if (kind < 80) begin
				repeat ($urandom_range(4, 12)) send_find();
			end else if (kind < 92) begin
				send_request(cls_pkg::OP_CLEAR, $urandom, cls_pkg::FI_W'($urandom),
					cls_pkg::LI_W'($urandom));
				repeat ($urandom_range(4, 12)) send_append();
			end else begin
				repeat ($urandom_range(2, 6)) send_noise();
			end
			if (!paused_midway && requests_sent >= midway) begin
				wait_for_replies();
				paused_midway = 1'b1;
			end
		end

		wait_for_replies();
		repeat (16) @(posedge clk);
		if (sb.failures == 0 && sb.awaited_replies.size() == 0)
			$display("compacting_list_store_top verification clean");
		else
			$display("compacting_list_store_top verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/cls_pkg.sv
design/cls_cell.sv
design/cls_seg.sv
design/compacting_list_store_top.sv
design/cls_checker.sv
test/compacting_list_store_top_tb.sv
